// ===== hdl/ccsd_pkg.sv =====
// Shared types and constants for the complex correlator sync detector.
package ccsd_pkg;

  localparam int TAPS_DEFAULT = 256;
  localparam int WORD_W       = 32;
  localparam int HALF_W       = 16;
  localparam int IDX_W        = 8;
  localparam int ADDR_SLOTS   = 2 ** IDX_W;
  localparam int METRIC_W     = 48;
  localparam int THR_W        = 48;
  localparam int COUNT_W      = 32;

  localparam logic [THR_W-1:0]    THR_RESET  = 48'h0_0000_0006_9000;
  localparam logic [METRIC_W-1:0] METRIC_MAX = {METRIC_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

  // operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [IDX_W-1:0]  coeff_index;
    logic [WORD_W-1:0] packed_value;
  } in_item_t;

  typedef struct packed {
    logic [METRIC_W-1:0] metric;
    logic                detected;
    logic [COUNT_W-1:0]  sample_index;
  } out_item_t;

  // per-cell controls
  typedef struct packed {
    logic shift;   // new sample enters, line moves one slot
    logic rotate;  // circular move of sample and coefficient
    logic we;      // coefficient write
  } cell_ctl_t;

  // accumulator controls
  typedef struct packed {
    logic clear;
    logic tap_valid;
    logic tap_last;
    logic take;
  } mac_ctl_t;

endpackage

// ===== hdl/ccsd_cell.sv =====
// One tap cell: holds a delay-line sample and its coefficient.
module ccsd_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccsd_pkg::cell_ctl_t           ctl,
  input  logic [ccsd_pkg::WORD_W-1:0]   sample_in,
  input  logic [ccsd_pkg::WORD_W-1:0]   coeff_in,
  input  logic [ccsd_pkg::WORD_W-1:0]   wdata,
  output logic [ccsd_pkg::WORD_W-1:0]   sample_q,
  output logic [ccsd_pkg::WORD_W-1:0]   coeff_q
);

  logic [ccsd_pkg::WORD_W-1:0] sample_r, sample_nxt;
  logic [ccsd_pkg::WORD_W-1:0] coeff_r, coeff_nxt;

  always_comb begin
    sample_nxt = sample_r;
    coeff_nxt  = coeff_r;
    if (ctl.shift || ctl.rotate) begin
      sample_nxt = sample_in;
    end
    if (ctl.rotate) begin
      coeff_nxt = coeff_in;
    end else if (ctl.we) begin
      coeff_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      coeff_r  <= '0;
    end else begin
      sample_r <= sample_nxt;
      coeff_r  <= coeff_nxt;
    end
  end

  assign sample_q = sample_r;
  assign coeff_q  = coeff_r;

endmodule

// ===== hdl/ccsd_mac.sv =====
// Complex multiply-accumulate, squared magnitude and saturation.
module ccsd_mac #(
  parameter int TAPS = ccsd_pkg::TAPS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ccsd_pkg::mac_ctl_t            ctl,
  input  logic [ccsd_pkg::WORD_W-1:0]   sample,
  input  logic [ccsd_pkg::WORD_W-1:0]   coeff,
  output logic                          res_valid,
  output logic [ccsd_pkg::METRIC_W-1:0] metric
);

  localparam int HW     = ccsd_pkg::HALF_W;
  localparam int ACC_W  = $clog2(TAPS) + HW + 1;
  localparam int SQ_W   = 2 * ACC_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int WIDE_W = (SUM_W > ccsd_pkg::METRIC_W) ? SUM_W : ccsd_pkg::METRIC_W;

  logic signed [HW-1:0]   sr, si, cr, ci;
  logic signed [2*HW-1:0] p_rr, p_ii, p_ri, p_ir;

  logic signed [HW-1:0] rr_r, ii_r, ri_r, ir_r;
  logic                 p_vld_r, p_vld_nxt;
  logic                 p_last_r, p_last_nxt;

  logic signed [ACC_W-1:0] acc_re_r, acc_re_nxt;
  logic signed [ACC_W-1:0] acc_im_r, acc_im_nxt;
  logic                    done_r, done_nxt;

  logic signed [SQ_W-1:0] sq_re_nxt, sq_im_nxt;
  logic [SQ_W-1:0]        sq_re_r, sq_im_r;
  logic                   sq_vld_r, sq_vld_nxt;

  logic [WIDE_W-1:0]             sum_ext;
  logic [ccsd_pkg::METRIC_W-1:0] metric_r, metric_nxt;
  logic                          res_vld_r, res_vld_nxt;

  assign sr = sample[2*HW-1:HW];
  assign si = sample[HW-1:0];
  assign cr = coeff[2*HW-1:HW];
  assign ci = coeff[HW-1:0];

  assign p_rr = sr * cr;
  assign p_ii = si * ci;
  assign p_ri = sr * ci;
  assign p_ir = cr * si;

  // floor(p / 2^16) is the upper half of the product
  always_ff @(posedge clk) begin
    if (ctl.tap_valid) begin
      rr_r <= p_rr[2*HW-1:HW];
      ii_r <= p_ii[2*HW-1:HW];
      ri_r <= p_ri[2*HW-1:HW];
      ir_r <= p_ir[2*HW-1:HW];
    end
  end

  always_comb begin
    p_vld_nxt  = ctl.tap_valid;
    p_last_nxt = ctl.tap_valid && ctl.tap_last;

    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (ctl.clear) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (p_vld_r) begin
      acc_re_nxt = acc_re_r + ACC_W'(rr_r) - ACC_W'(ii_r);
      acc_im_nxt = acc_im_r + ACC_W'(ri_r) + ACC_W'(ir_r);
    end
    done_nxt = p_vld_r && p_last_r;

    sq_re_nxt  = acc_re_r * acc_re_r;
    sq_im_nxt  = acc_im_r * acc_im_r;
    sq_vld_nxt = done_r;

    sum_ext    = WIDE_W'(sq_re_r) + WIDE_W'(sq_im_r);
    metric_nxt = metric_r;
    if (sq_vld_r) begin
      metric_nxt = (sum_ext > WIDE_W'(ccsd_pkg::METRIC_MAX)) ? ccsd_pkg::METRIC_MAX
                                                             : sum_ext[ccsd_pkg::METRIC_W-1:0];
    end

    res_vld_nxt = res_vld_r;
    if (sq_vld_r) begin
      res_vld_nxt = 1'b1;
    end else if (ctl.take) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_re_r <= acc_re_nxt;
    acc_im_r <= acc_im_nxt;
    metric_r <= metric_nxt;
    if (done_r) begin
      sq_re_r <= sq_re_nxt;
      sq_im_r <= sq_im_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      p_last_r  <= 1'b0;
      done_r    <= 1'b0;
      sq_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= p_vld_nxt;
      p_last_r  <= p_last_nxt;
      done_r    <= done_nxt;
      sq_vld_r  <= sq_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  assign res_valid = res_vld_r;
  assign metric    = metric_r;

endmodule

// ===== hdl/complex_correlator_sync_detect.sv =====
// Top level of the complex correlator sync detector: tap cell row and sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t  (operation, index, word)
//   out_    | output    | out_valid/out_stall| out_item_t (metric, flag, index)
//   cfg_    | input     | cfg_valid/cfg_ready| 48-bit detect threshold
//
// A coefficient load is written straight into its cell and the block stays idle.
// After a sample transfer, in_stall stays high until its result enters the output
// register: the tap row rotates once around past a single complex MAC, then the
// product, accumulate, square, saturate and output register stages follow.
// rst_n is synchronous; it clears the delay line, the sample count and the
// threshold (to 0x69000). A finished result waits in the output register while
// out_stall is high; the next item may be taken meanwhile, and its result waits
// for the register to free.
module complex_correlator_sync_detect #(
  parameter int TAPS = ccsd_pkg::TAPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ccsd_pkg::in_item_t         in_data,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output ccsd_pkg::out_item_t        out_data,
  // threshold write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ccsd_pkg::THR_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(TAPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] rot_cnt_r, rot_cnt_nxt;

  logic [ccsd_pkg::THR_W-1:0]   thr_r, thr_nxt;
  logic [ccsd_pkg::COUNT_W-1:0] sample_count_r, sample_count_nxt;

  logic                out_valid_r, out_valid_nxt;
  ccsd_pkg::out_item_t out_data_r, out_data_nxt;

  logic in_xfer, smp_xfer, load_xfer, out_free, out_load;

  // tap row
  logic [ccsd_pkg::WORD_W-1:0] smp_q  [TAPS];
  logic [ccsd_pkg::WORD_W-1:0] coef_q [TAPS];
  logic [ccsd_pkg::WORD_W-1:0] smp_head;
  logic                        rotating;

  ccsd_pkg::mac_ctl_t              mac_ctl;
  logic                            mac_res_valid;
  logic [ccsd_pkg::METRIC_W-1:0]   mac_metric;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign smp_xfer  = in_xfer && (in_data.operation == ccsd_pkg::OP_SAMPLE);
  assign load_xfer = in_xfer && (in_data.operation == ccsd_pkg::OP_LOAD);
  assign rotating  = (state_r == ST_ROT);

  // On a sample the new word enters slot 0; while rotating the tail wraps to
  // slot 0 so every slot passes the MAC once and ends back at home.
  assign smp_head = smp_xfer ? in_data.packed_value : smp_q[TAPS-1];

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    ccsd_pkg::cell_ctl_t         cctl;
    logic [ccsd_pkg::WORD_W-1:0] s_in, c_in;

    assign cctl.shift  = smp_xfer;
    assign cctl.rotate = rotating;

    // slots past the index range can never be written
    if (k < ccsd_pkg::ADDR_SLOTS) begin : g_we
      assign cctl.we = load_xfer && (in_data.coeff_index == ccsd_pkg::IDX_W'(k));
    end else begin : g_nowe
      assign cctl.we = 1'b0;
    end

    if (k == 0) begin : g_first
      assign s_in = smp_head;
      assign c_in = coef_q[TAPS-1];
    end else begin : g_rest
      assign s_in = smp_q[k-1];
      assign c_in = coef_q[k-1];
    end

    ccsd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cctl),
      .sample_in (s_in),
      .coeff_in  (c_in),
      .wdata     (in_data.packed_value),
      .sample_q  (smp_q[k]),
      .coeff_q   (coef_q[k])
    );
  end

  // MAC reads the tail cell; one tap per rotation cycle
  assign mac_ctl.clear     = smp_xfer;
  assign mac_ctl.tap_valid = rotating;
  assign mac_ctl.tap_last  = (rot_cnt_r == CNT_LAST);
  assign mac_ctl.take      = out_load;

  ccsd_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .sample    (smp_q[TAPS-1]),
    .coeff     (coef_q[TAPS-1]),
    .res_valid (mac_res_valid),
    .metric    (mac_metric)
  );

  // output register frees when empty or when its transfer happens
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_WAIT) && mac_res_valid && out_free;

  always_comb begin
    state_nxt   = state_r;
    rot_cnt_nxt = rot_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_xfer) begin
          state_nxt   = ST_ROT;
          rot_cnt_nxt = '0;
        end
      end
      ST_ROT: begin
        rot_cnt_nxt = rot_cnt_r + 1'b1;
        if (rot_cnt_r == CNT_LAST) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    thr_nxt = cfg_valid ? cfg_data : thr_r;

    sample_count_nxt = sample_count_r;
    out_data_nxt     = out_data_r;
    out_valid_nxt    = out_valid_r && out_stall;
    if (out_load) begin
      out_data_nxt.metric       = mac_metric;
      out_data_nxt.detected     = (mac_metric >= thr_r);
      out_data_nxt.sample_index = sample_count_r;
      out_valid_nxt             = 1'b1;
      if (sample_count_r != ccsd_pkg::COUNT_MAX) begin
        sample_count_nxt = sample_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      rot_cnt_r      <= '0;
      thr_r          <= ccsd_pkg::THR_RESET;
      sample_count_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      rot_cnt_r      <= rot_cnt_nxt;
      thr_r          <= thr_nxt;
      sample_count_r <= sample_count_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result only comes out of the wait state
  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WAIT))
    else $error("result appeared outside the wait state");

  // the MAC holds no finished result while the block is idle
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_res_valid)
    else $error("stale MAC result while idle");

  // sample count never moves backward
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r >= $past(sample_count_r))
    else $error("sample count decreased");

  // a sample transfer always starts a full rotation from slot zero
  a_smp_starts_rot: assert property (@(posedge clk) disable iff (!rst_n)
    smp_xfer |=> (state_r == ST_ROT) && (rot_cnt_r == '0))
    else $error("sample did not start rotation");

endmodule

// ===== sim/complex_correlator_sync_detect_tb.sv =====
// Self-checking testbench for the complex correlator sync detector.
module complex_correlator_sync_detect_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAPS       = ccsd_pkg::TAPS_DEFAULT;
  localparam int HOLD_CYCLES = 2000;   // long receiver hold-off for the fill-up test

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  ccsd_pkg::in_item_t         in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  ccsd_pkg::out_item_t        out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [ccsd_pkg::THR_W-1:0] cfg_data  = '0;

  always #5 clk = ~clk;

  complex_correlator_sync_detect #(.TAPS(NTAPS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Correlator state mirror: window of samples, tap coefficients, sample
  // counter and threshold, as the block should hold them after each transfer.
  // ---------------------------------------------------------------------------
  logic [ccsd_pkg::WORD_W-1:0]  corr_window [NTAPS];
  logic [ccsd_pkg::WORD_W-1:0]  tap_coeff   [NTAPS];
  logic [ccsd_pkg::COUNT_W-1:0] samples_seen = '0;
  logic [ccsd_pkg::THR_W-1:0]   thr_setting  = ccsd_pkg::THR_RESET;
  ccsd_pkg::out_item_t          pending_results[$];   // expected results, oldest first

  int err_cnt      = 0;
  int in_idle_pct  = 0;   // chance per cycle that the sender holds back
  int out_idle_pct = 0;   // chance per cycle that the receiver stalls

  // hold-off request: the test flips hold_req, the stall process notices it
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  initial begin
    for (int k = 0; k < NTAPS; k++) corr_window[k] = '0;
  end

  // |sum of tap products|^2 for the window as it would look once `newest`
  // has shifted in. Each of the four partial products is floored by 2^16.
  function automatic logic [ccsd_pkg::METRIC_W-1:0] window_metric(
      input logic [ccsd_pkg::WORD_W-1:0] newest);
    longint      acc_re, acc_im;
    logic [63:0] mag;
    logic [ccsd_pkg::WORD_W-1:0] s, c;
    int          sr, si, cr, ci;
    acc_re = 0;
    acc_im = 0;
    for (int k = 0; k < NTAPS; k++) begin
      s  = (k == 0) ? newest : corr_window[k-1];
      c  = tap_coeff[k];
      sr = $signed(s[ccsd_pkg::WORD_W-1:ccsd_pkg::HALF_W]);
      si = $signed(s[ccsd_pkg::HALF_W-1:0]);
      cr = $signed(c[ccsd_pkg::WORD_W-1:ccsd_pkg::HALF_W]);
      ci = $signed(c[ccsd_pkg::HALF_W-1:0]);
      // signed >>> floors, matching the block's scaling
      acc_re += ((sr * cr) >>> ccsd_pkg::HALF_W) - ((si * ci) >>> ccsd_pkg::HALF_W);
      acc_im += ((sr * ci) >>> ccsd_pkg::HALF_W) + ((cr * si) >>> ccsd_pkg::HALF_W);
    end
    mag = acc_re * acc_re + acc_im * acc_im;
    if (mag > 64'(ccsd_pkg::METRIC_MAX)) mag = 64'(ccsd_pkg::METRIC_MAX);
    return mag[ccsd_pkg::METRIC_W-1:0];
  endfunction

  // Update the mirror for one accepted item; a sample queues its result.
  task automatic record_transfer(input ccsd_pkg::in_item_t item);
    ccsd_pkg::out_item_t res;
    if (item.operation == ccsd_pkg::OP_LOAD) begin
      if (int'(item.coeff_index) < NTAPS) tap_coeff[item.coeff_index] = item.packed_value;
    end else begin
      res.metric       = window_metric(item.packed_value);
      res.detected     = (res.metric >= thr_setting);
      res.sample_index = samples_seen;
      for (int k = NTAPS - 1; k > 0; k--) corr_window[k] = corr_window[k-1];
      corr_window[0] = item.packed_value;
      if (samples_seen != ccsd_pkg::COUNT_MAX) samples_seen++;
      pending_results.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge, returns at the edge of the transfer with
  // in_valid still high, so back-to-back items keep valid up without a dip.
  // ---------------------------------------------------------------------------
  task automatic send_item(input ccsd_pkg::in_item_t item);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_transfer(item);
  endtask

  // Quiet the input, wait for every result, then let a full rotation pass so
  // a trailing coefficient load has surely landed too.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NTAPS + 8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ccsd_pkg::THR_W-1:0] v);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    thr_setting  = v;
  endtask

  // Random 16-bit part: mostly scaled noise, sometimes a corner value.
  function automatic logic [ccsd_pkg::HALF_W-1:0] rand_half(input int sh);
    logic signed [ccsd_pkg::HALF_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = '0;
      3:       v = 16'hFFFF;
      default: v = $signed(ccsd_pkg::HALF_W'($urandom)) >>> sh;
    endcase
    return v;
  endfunction

  function automatic logic [ccsd_pkg::WORD_W-1:0] rand_word(input int sh);
    return {rand_half(sh), rand_half(sh)};
  endfunction

  function automatic ccsd_pkg::in_item_t make_item(input logic op, input int idx,
                                                   input logic [ccsd_pkg::WORD_W-1:0] word);
    ccsd_pkg::in_item_t item;
    item.operation    = op;
    item.coeff_index  = ccsd_pkg::IDX_W'(idx);
    item.packed_value = word;
    return item;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off when the test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer on the result side against the oldest
  // expectation, field by field
  // ---------------------------------------------------------------------------
  function automatic void log_mismatch(input string what, input logic [63:0] exp_v,
                                       input logic [63:0] act_v);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, exp_v, act_v);
  endfunction

  always @(posedge clk) begin
    ccsd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_mismatch("unexpected result (expected none), metric", '0,
                     64'(out_data.metric));
      end else begin
        want = pending_results.pop_front();
        if (out_data.metric !== want.metric)
          log_mismatch("metric", 64'(want.metric), 64'(out_data.metric));
        if (out_data.detected !== want.detected)
          log_mismatch("detected", 64'(want.detected), 64'(out_data.detected));
        if (out_data.sample_index !== want.sample_index)
          log_mismatch("sample_index", 64'(want.sample_index), 64'(out_data.sample_index));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every slot gets written before the first sample: an unwritten slot must
  // never be read. Corner coefficients sit at both ends of the store.
  task automatic test_coeff_fill();
    logic [ccsd_pkg::WORD_W-1:0] w;
    for (int i = 0; i < NTAPS; i++) begin
      case (i)
        0:         w = 32'h7FFF_7FFF;
        1:         w = 32'h8000_8000;
        2:         w = 32'h8000_7FFF;
        NTAPS - 1: w = 32'h7FFF_8000;
        default:   w = rand_word(0);
      endcase
      send_item(make_item(ccsd_pkg::OP_LOAD, i, w));
    end
  endtask

  // Extreme samples under the reset threshold; the index field on a sample
  // is ignored, so it carries junk here.
  task automatic test_sample_extremes();
    logic [ccsd_pkg::WORD_W-1:0] words [8] = '{32'h0000_0000, 32'h7FFF_7FFF, 32'h8000_8000,
                                               32'h8000_7FFF, 32'h7FFF_8000, 32'hFFFF_FFFF,
                                               32'h0001_0001, 32'h8000_0000};
    for (int i = 0; i < 8; i++)
      send_item(make_item(ccsd_pkg::OP_SAMPLE, (i % 2) ? 8'hFF : 8'hAA, words[i]));
  endtask

  // Loads in between samples produce nothing and take effect at once.
  task automatic test_load_between_samples();
    send_item(make_item(ccsd_pkg::OP_LOAD, 0, 32'h8000_8000));
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 0, 32'h7FFF_0001));
    send_item(make_item(ccsd_pkg::OP_LOAD, NTAPS - 1, 32'h0000_0000));
    send_item(make_item(ccsd_pkg::OP_LOAD, 0, 32'h0001_0000));
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 255, 32'hFFFF_8000));
  endtask

  // Threshold at both extremes, then exactly at and one above the metric the
  // next sample is going to give.
  task automatic test_threshold_edges();
    logic [ccsd_pkg::WORD_W-1:0] w;
    write_threshold('0);
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 0, 32'h1234_8765));
    write_threshold({ccsd_pkg::THR_W{1'b1}});
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 0, 32'h8000_8000));
    w = 32'h7FFF_8000;
    write_threshold(window_metric(w));
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 0, w));
    w = 32'h4000_C000;
    write_threshold(window_metric(w) + 1);
    send_item(make_item(ccsd_pkg::OP_SAMPLE, 0, w));
  endtask

  // Receiver holds off for a long stretch while samples keep coming: the
  // output register fills, the next result waits, and in_stall must rise.
  task automatic test_output_backpressure();
    drain_block();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req    <= ~hold_req;
    for (int i = 0; i < 10; i++)
      send_item(make_item(ccsd_pkg::OP_SAMPLE, $urandom_range(255),
                          rand_word($urandom_range(8))));
  endtask

  // Bursts of coefficient rewrites and sample runs with per-burst amplitude,
  // with an odd load dropped into sample runs.
  task automatic run_random_phase(input int n_items, input int in_pct, input int out_pct,
                                  input logic [ccsd_pkg::THR_W-1:0] thr);
    ccsd_pkg::in_item_t item;
    int       sent, burst, base, sh;
    bit       loads;
    write_threshold(thr);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    while (sent < n_items) begin
      loads = ($urandom_range(99) < 30);
      burst = loads ? $urandom_range(1, 16) : $urandom_range(1, 12);
      base  = $urandom_range(255);
      sh    = $urandom_range(15);
      for (int i = 0; i < burst; i++) begin
        item = make_item(loads ? ccsd_pkg::OP_LOAD : ccsd_pkg::OP_SAMPLE, base + i,
                         rand_word(sh));
        if (!loads && $urandom_range(19) == 0) item.operation = ccsd_pkg::OP_LOAD;
        send_item(item);
      end
      sent += burst;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_idle_pct  = 10;
    out_idle_pct = 30;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_coeff_fill();
    test_sample_extremes();
    test_load_between_samples();
    test_threshold_edges();
    test_output_backpressure();
    run_random_phase(500, 21, 88, 48'h0000_4000_0000);
    run_random_phase(500, 88, 21, 48'(1) << $urandom_range(20, 40));
    run_random_phase(500, 0, 0, ccsd_pkg::THR_RESET);

    drain_block();
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as failing, well after a
  // correct run would have finished.
  initial begin
    #(30_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== complex_correlator_sync_detect.f =====
hdl/ccsd_pkg.sv
hdl/ccsd_cell.sv
hdl/ccsd_mac.sv
hdl/complex_correlator_sync_detect.sv
sim/complex_correlator_sync_detect_tb.sv
